// ===== src/lcdbp_pkg.sv =====
// Shared types and constants for the LCD backpack byte writer.
package lcdbp_pkg;

    // Item command codes
    localparam logic C_CMD_TICK = 1'b0;
    localparam logic C_CMD_SEND = 1'b1;

    // Expander byte bits and reset address
    localparam logic [7:0] C_BACKLIGHT  = 8'h08;
    localparam logic [7:0] C_ENABLE     = 8'h04;
    localparam logic [6:0] C_ADDR_RESET = 7'h27;

    // Phase landmarks within one transaction
    localparam logic [6:0] C_PH_START_SDA = 7'd0;
    localparam logic [6:0] C_PH_START_SCL = 7'd1;
    localparam logic [6:0] C_PH_BYTES_LO  = 7'd2;
    localparam logic [6:0] C_PH_STOP_SDA  = 7'd110;
    localparam logic [6:0] C_PH_STOP_SCL  = 7'd111;
    localparam logic [6:0] C_PH_LAST      = 7'd112;

    // Position within a byte: slot 0..7 are data bits, slot 8 is acknowledge
    localparam logic [3:0] C_SLOT_ACK  = 4'd8;
    localparam logic [1:0] C_SUB_DATA  = 2'd0;
    localparam logic [1:0] C_SUB_RISE  = 2'd1;
    localparam logic [1:0] C_SUB_FALL  = 2'd2;

    // Byte order within a transaction
    localparam logic [1:0] C_BYTE_ADDR   = 2'd0;
    localparam logic [1:0] C_BYTE_ENABLE = 2'd2;
    localparam logic [1:0] C_BYTE_LAST   = 2'd3;

    // Line change for one phase
    typedef struct packed {
        logic set_scl;
        logic scl;
        logic set_sda;
        logic sda;
    } t_line_act;

    // Result of one item
    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic rejected;
    } t_step_res;

endpackage

// ===== src/lcdbp_phase_dec.sv =====
// Phase decoder: which bus line changes in the current phase.
module lcdbp_phase_dec (
    input  logic [6:0]           i_phase,
    input  logic [1:0]           i_which,
    input  logic [3:0]           i_slot,
    input  logic [1:0]           i_sub,
    input  logic                 i_txn,
    input  logic [7:0]           i_byte,
    input  logic                 i_select,
    input  logic [6:0]           i_addr,
    output lcdbp_pkg::t_line_act o_act
);

    logic [3:0] w_nib;
    logic [7:0] w_pcf;
    logic [7:0] w_wire;
    logic       w_in_bytes;

    // Build the byte on the wire
    always_comb begin
        w_nib = i_txn ? i_byte[3:0] : i_byte[7:4];
        w_pcf = {w_nib, 3'b000, i_select} | lcdbp_pkg::C_BACKLIGHT;
        if (i_which == lcdbp_pkg::C_BYTE_ADDR) begin
            w_wire = {i_addr, 1'b0};
        end else if (i_which == lcdbp_pkg::C_BYTE_ENABLE) begin
            w_wire = w_pcf | lcdbp_pkg::C_ENABLE;
        end else begin
            w_wire = w_pcf;
        end
    end

    assign w_in_bytes = (i_phase >= lcdbp_pkg::C_PH_BYTES_LO) &&
                        (i_phase <  lcdbp_pkg::C_PH_STOP_SDA);

    // Decode the line change
    always_comb begin
        o_act = '0;
        if (i_phase == lcdbp_pkg::C_PH_START_SDA) begin
            o_act.set_sda = 1'b1;
            o_act.sda     = 1'b0;
        end else if (i_phase == lcdbp_pkg::C_PH_START_SCL) begin
            o_act.set_scl = 1'b1;
            o_act.scl     = 1'b0;
        end else if (w_in_bytes) begin
            case (i_sub)
                lcdbp_pkg::C_SUB_DATA: begin
                    o_act.set_sda = 1'b1;
                    if (i_slot == lcdbp_pkg::C_SLOT_ACK) begin
                        o_act.sda = 1'b1;
                    end else begin
                        o_act.sda = w_wire[3'd7 - i_slot[2:0]];
                    end
                end
                lcdbp_pkg::C_SUB_RISE: begin
                    o_act.set_scl = 1'b1;
                    o_act.scl     = 1'b1;
                end
                default: begin
                    o_act.set_scl = 1'b1;
                    o_act.scl     = 1'b0;
                end
            endcase
        end else if (i_phase == lcdbp_pkg::C_PH_STOP_SDA) begin
            o_act.set_sda = 1'b1;
            o_act.sda     = 1'b0;
        end else if (i_phase == lcdbp_pkg::C_PH_STOP_SCL) begin
            o_act.set_scl = 1'b1;
            o_act.scl     = 1'b1;
        end else if (i_phase == lcdbp_pkg::C_PH_LAST) begin
            o_act.set_sda = 1'b1;
            o_act.sda     = 1'b1;
        end
    end

endmodule

// ===== src/lcdbp_seq.sv =====
// Bus sequencer: transaction state and the step for one item.
module lcdbp_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_command,
    input  logic [7:0]           i_lcd_byte,
    input  logic                 i_register_select,
    input  logic                 i_high_nibble_only,
    input  logic [6:0]           i_addr,
    output lcdbp_pkg::t_step_res o_res
);

    logic [6:0] r_phase, n_phase;
    logic [1:0] r_which, n_which;
    logic [3:0] r_slot,  n_slot;
    logic [1:0] r_sub,   n_sub;
    logic       r_txn,   n_txn;
    logic [7:0] r_byte,  n_byte;
    logic       r_sel,   n_sel;
    logic       r_single, n_single;
    logic       r_active, n_active;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       w_rejected;
    logic       w_in_bytes;

    lcdbp_pkg::t_line_act w_act;

    lcdbp_phase_dec u_dec (
        .i_phase  (r_phase),
        .i_which  (r_which),
        .i_slot   (r_slot),
        .i_sub    (r_sub),
        .i_txn    (r_txn),
        .i_byte   (r_byte),
        .i_select (r_sel),
        .i_addr   (i_addr),
        .o_act    (w_act)
    );

    assign w_in_bytes = (r_phase >= lcdbp_pkg::C_PH_BYTES_LO) &&
                        (r_phase <  lcdbp_pkg::C_PH_STOP_SDA);

    // Next state for one item
    always_comb begin
        n_phase    = r_phase;
        n_which    = r_which;
        n_slot     = r_slot;
        n_sub      = r_sub;
        n_txn      = r_txn;
        n_byte     = r_byte;
        n_sel      = r_sel;
        n_single   = r_single;
        n_active   = r_active;
        n_scl      = r_scl;
        n_sda      = r_sda;
        w_rejected = 1'b0;
        if (i_command == lcdbp_pkg::C_CMD_SEND) begin
            if (r_active) begin
                w_rejected = 1'b1;
            end else begin
                n_byte   = i_lcd_byte;
                n_sel    = i_register_select;
                n_single = i_high_nibble_only;
                n_phase  = '0;
                n_which  = '0;
                n_slot   = '0;
                n_sub    = '0;
                n_txn    = 1'b0;
                n_active = 1'b1;
            end
        end else if (r_active) begin
            // Apply the line change
            if (w_act.set_scl) begin
                n_scl = w_act.scl;
            end
            if (w_act.set_sda) begin
                n_sda = w_act.sda;
            end
            // Advance the position counters
            if (w_in_bytes) begin
                if (r_sub == lcdbp_pkg::C_SUB_FALL) begin
                    n_sub = '0;
                    if (r_slot == lcdbp_pkg::C_SLOT_ACK) begin
                        n_slot  = '0;
                        n_which = (r_which == lcdbp_pkg::C_BYTE_LAST) ? 2'd0 : r_which + 2'd1;
                    end else begin
                        n_slot = r_slot + 4'd1;
                    end
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            // End of transaction
            if (r_phase >= lcdbp_pkg::C_PH_LAST) begin
                n_phase = '0;
                n_which = '0;
                n_slot  = '0;
                n_sub   = '0;
                if (!r_txn && !r_single) begin
                    n_txn = 1'b1;
                end else begin
                    n_txn    = 1'b0;
                    n_active = 1'b0;
                end
            end else begin
                n_phase = r_phase + 7'd1;
            end
        end
    end

    // Hold state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_which  <= '0;
            r_slot   <= '0;
            r_sub    <= '0;
            r_txn    <= 1'b0;
            r_byte   <= '0;
            r_sel    <= 1'b0;
            r_single <= 1'b0;
            r_active <= 1'b0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_which  <= n_which;
            r_slot   <= n_slot;
            r_sub    <= n_sub;
            r_txn    <= n_txn;
            r_byte   <= n_byte;
            r_sel    <= n_sel;
            r_single <= n_single;
            r_active <= n_active;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
        end
    end

    assign o_res.scl      = n_scl;
    assign o_res.sda      = n_sda;
    assign o_res.busy     = n_active;
    assign o_res.rejected = w_rejected;

endmodule

// ===== src/i2c_lcd_backpack_byte_writer.sv =====
// Top level of the I2C LCD backpack byte writer.
//
// Input channel (i_valid / o_stall) carries one item: a tick that moves the
// bit-banged I2C sequence by one line change, or a send command with an LCD
// byte, its register-select bit and a high-nibble-only flag. Each nibble is
// sent as one 113-tick transaction to the port expander.
// Output channel (o_valid / i_stall) returns one result per item: the SCL and
// SDA levels after it, the busy flag and a flag for a dropped send.
// An item is registered on acceptance and its result is registered in the
// result stage. One item per cycle is sustained unless the receiver stalls;
// the state update for an item is a single pass through the phase decoder.
// The device address register is written with i_cfg_wr_en; the user must
// write it only while idle; the block does not enforce it. Reset clears both
// stages, leaves both lines released (high), the block idle and the address
// at 0x27. When the receiver stalls, the result holds and the input stage
// fills; o_stall rises once the input stage holds an item that cannot move.
module i2c_lcd_backpack_byte_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_command,
    input  logic [7:0] i_lcd_byte,
    input  logic       i_register_select,
    input  logic       i_high_nibble_only,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_rejected,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data
);

    logic       r_addr;
    logic [6:0] r_dev_addr;
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;
    logic       r_in_sel;
    logic       r_in_single;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_step;

    lcdbp_pkg::t_step_res w_res;
    lcdbp_pkg::t_step_res r_res;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    // Hold the device address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= lcdbp_pkg::C_ADDR_RESET;
            r_addr     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
            r_addr     <= 1'b1;
        end
    end

    // Input stage: take an item whenever the stage is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_cmd    <= i_command;
            r_in_byte   <= i_lcd_byte;
            r_in_sel    <= i_register_select;
            r_in_single <= i_high_nibble_only;
        end
    end

    lcdbp_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_step),
        .i_command          (r_in_cmd),
        .i_lcd_byte         (r_in_byte),
        .i_register_select  (r_in_sel),
        .i_high_nibble_only (r_in_single),
        .i_addr             (r_dev_addr),
        .o_res              (w_res)
    );

    // Result stage: load when free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_res.scl;
    assign o_sda_level = r_res.sda;
    assign o_busy_res  = r_res.busy;
    assign o_rejected  = r_res.rejected;

    // A dropped send only happens while busy
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_busy_res)
        else $error("rejected result without busy");

    // Idle results show both lines released
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> o_scl_level && o_sda_level)
        else $error("idle with a line driven low");

    // A stepped item always lands in the result stage
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("stepped item lost");

    // The address register changes only on a write
    a_addr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cfg_wr_en) && $past(r_addr) |-> $stable(r_dev_addr))
        else $error("device address changed without a write");

endmodule

// ===== bench/lcdbp_line_monitor.sv =====
// Line-level predictor and result comparator for the LCD backpack byte writer.
`timescale 1ns / 100ps

module lcdbp_line_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_lcd_byte,
    input  logic       i_register_select,
    input  logic       i_high_nibble_only,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_scl_level,
    input  logic       i_sda_level,
    input  logic       i_busy_res,
    input  logic       i_rejected,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    output int         o_mismatches,
    output int         o_outstanding
);

    localparam int PHASES_PER_BYTE = 27;
    localparam int SUBS_PER_SLOT   = 3;

    // Shadow copy of the writer state
    logic [6:0] dev_addr;
    logic [6:0] phase;
    logic       second_nibble;
    logic [7:0] latched_byte;
    logic       latched_rs;
    logic       latched_single;
    logic       busy;
    logic       scl;
    logic       sda;

    lcdbp_pkg::t_step_res expected_lines[$];
    int                   mismatches = 0;

    // Byte on the wire for the current nibble: address, expander, strobe, expander
    function automatic logic [7:0] frame_byte(input logic [1:0] which);
        logic [3:0] nib;
        logic [7:0] pcf;
        nib = second_nibble ? latched_byte[3:0] : latched_byte[7:4];
        pcf = {nib, 4'b0000} | lcdbp_pkg::C_BACKLIGHT | {7'b0000000, latched_rs};
        if (which == lcdbp_pkg::C_BYTE_ADDR)
            return {dev_addr, 1'b0};
        if (which == lcdbp_pkg::C_BYTE_ENABLE)
            return pcf | lcdbp_pkg::C_ENABLE;
        return pcf;
    endfunction

    // Apply the line change of one phase
    task automatic drive_phase(input logic [6:0] ph);
        int         offs;
        int         slot;
        int         sub;
        logic [1:0] which;
        logic [7:0] wire_val;
        if (ph == lcdbp_pkg::C_PH_START_SDA) begin
            sda = 1'b0;
        end else if (ph == lcdbp_pkg::C_PH_START_SCL) begin
            scl = 1'b0;
        end else if (ph < lcdbp_pkg::C_PH_STOP_SDA) begin
            offs  = int'(ph) - int'(lcdbp_pkg::C_PH_BYTES_LO);
            which = 2'(offs / PHASES_PER_BYTE);
            slot  = (offs % PHASES_PER_BYTE) / SUBS_PER_SLOT;
            sub   = (offs % PHASES_PER_BYTE) % SUBS_PER_SLOT;
            if (sub == int'(lcdbp_pkg::C_SUB_DATA)) begin
                wire_val = frame_byte(which);
                // acknowledge slot releases the data line, it is never sampled
                sda = (slot < int'(lcdbp_pkg::C_SLOT_ACK)) ? wire_val[7 - slot] : 1'b1;
            end else begin
                scl = (sub == int'(lcdbp_pkg::C_SUB_RISE));
            end
        end else if (ph == lcdbp_pkg::C_PH_STOP_SDA) begin
            sda = 1'b0;
        end else if (ph == lcdbp_pkg::C_PH_STOP_SCL) begin
            scl = 1'b1;
        end else if (ph == lcdbp_pkg::C_PH_LAST) begin
            sda = 1'b1;
        end
    endtask

    // Advance the shadow state by one item and queue the line levels it leaves
    task automatic step_bus(input logic cmd, input logic [7:0] byte_in,
                            input logic rs, input logic hn);
        lcdbp_pkg::t_step_res res;
        res.rejected = 1'b0;
        if (cmd == lcdbp_pkg::C_CMD_SEND) begin
            if (busy) begin
                // a send while busy is dropped
                res.rejected = 1'b1;
            end else begin
                latched_byte   = byte_in;
                latched_rs     = rs;
                latched_single = hn;
                phase          = lcdbp_pkg::C_PH_START_SDA;
                second_nibble  = 1'b0;
                busy           = 1'b1;
            end
        end else if (busy) begin
            drive_phase(phase);
            if (phase >= lcdbp_pkg::C_PH_LAST) begin
                phase = lcdbp_pkg::C_PH_START_SDA;
                if (!second_nibble && !latched_single) begin
                    second_nibble = 1'b1;
                end else begin
                    second_nibble = 1'b0;
                    busy          = 1'b0;
                end
            end else begin
                phase = phase + 7'd1;
            end
        end
        res.scl  = scl;
        res.sda  = sda;
        res.busy = busy;
        expected_lines.push_back(res);
    endtask

    task automatic compare_line(input string field, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, got %0b", field, want, got);
            mismatches++;
        end
    endtask

    // Compare accepted results, then predict for accepted items
    always @(posedge i_clk) begin
        lcdbp_pkg::t_step_res want;
        if (!i_rst_n) begin
            dev_addr       = lcdbp_pkg::C_ADDR_RESET;
            phase          = lcdbp_pkg::C_PH_START_SDA;
            second_nibble  = 1'b0;
            latched_byte   = 8'h00;
            latched_rs     = 1'b0;
            latched_single = 1'b0;
            busy           = 1'b0;
            scl            = 1'b1;
            sda            = 1'b1;
            expected_lines.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_lines.size() == 0) begin
                    $error("result with no item waiting: scl %0b sda %0b busy %0b rejected %0b",
                           i_scl_level, i_sda_level, i_busy_res, i_rejected);
                    mismatches++;
                end else begin
                    want = expected_lines.pop_front();
                    compare_line("scl_level", want.scl, i_scl_level);
                    compare_line("sda_level", want.sda, i_sda_level);
                    compare_line("busy_res", want.busy, i_busy_res);
                    compare_line("rejected", want.rejected, i_rejected);
                end
            end
            if (i_in_valid && !i_in_stall)
                step_bus(i_command, i_lcd_byte, i_register_select, i_high_nibble_only);
            if (i_cfg_wr_en)
                dev_addr = i_cfg_wr_data;
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_lines.size();
    end

endmodule

// ===== bench/i2c_lcd_backpack_byte_writer_tb.sv =====
// Stimulus, receiver stalls and verdict for the LCD backpack byte writer.
`timescale 1ns / 100ps

module i2c_lcd_backpack_byte_writer_tb;

    localparam int TICKS_PER_NIBBLE = int'(lcdbp_pkg::C_PH_LAST) + 1;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 6;
    localparam int PHASE_ITEMS      = 280;

    logic       i_clk              = 1'b0;
    logic       i_rst_n            = 1'b0;
    logic       i_valid            = 1'b0;
    logic       o_stall;
    logic       i_command          = lcdbp_pkg::C_CMD_TICK;
    logic [7:0] i_lcd_byte         = 8'h00;
    logic       i_register_select  = 1'b0;
    logic       i_high_nibble_only = 1'b0;
    logic       o_valid;
    logic       i_stall            = 1'b0;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_busy_res;
    logic       o_rejected;
    logic       i_cfg_wr_en        = 1'b0;
    logic [6:0] i_cfg_wr_data      = 7'd0;

    int mismatches;
    int outstanding;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_asks  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int ticks_left = 0;

    i2c_lcd_backpack_byte_writer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_lcd_byte         (i_lcd_byte),
        .i_register_select  (i_register_select),
        .i_high_nibble_only (i_high_nibble_only),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_scl_level        (o_scl_level),
        .o_sda_level        (o_sda_level),
        .o_busy_res         (o_busy_res),
        .o_rejected         (o_rejected),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    lcdbp_line_monitor u_line_monitor (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_command          (i_command),
        .i_lcd_byte         (i_lcd_byte),
        .i_register_select  (i_register_select),
        .i_high_nibble_only (i_high_nibble_only),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_scl_level        (o_scl_level),
        .i_sda_level        (o_sda_level),
        .i_busy_res         (o_busy_res),
        .i_rejected         (o_rejected),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one item after random idle cycles and hold it until accepted
    task automatic offer_item(input logic cmd, input logic [7:0] lcd_byte,
                              input logic rs, input logic hn);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_command          <= cmd;
        i_lcd_byte         <= lcd_byte;
        i_register_select  <= rs;
        i_high_nibble_only <= hn;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // track how many ticks the bus still needs to go idle
        if (cmd == lcdbp_pkg::C_CMD_SEND) begin
            if (ticks_left == 0)
                ticks_left = hn ? TICKS_PER_NIBBLE : 2 * TICKS_PER_NIBBLE;
        end else if (ticks_left != 0) begin
            ticks_left--;
        end
    endtask

    task automatic send_tick();
        offer_item(lcdbp_pkg::C_CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    endtask

    task automatic send_random_byte();
        offer_item(lcdbp_pkg::C_CMD_SEND, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    endtask

    // Run the bus idle, drain results, then write the expander address
    task automatic write_address(input logic [6:0] addr);
        while (ticks_left != 0)
            send_tick();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly complete byte sequences, with dropped sends and cut-short runs mixed in
    task automatic run_sequences(input int budget);
        int done;
        int n;
        done = 0;
        while (done < budget) begin
            send_random_byte();
            done++;
            n = ticks_left;
            if ($urandom_range(9) == 0)
                n = $urandom_range(n);
            repeat (n) begin
                if ($urandom_range(39) == 0) begin
                    send_random_byte();
                    done++;
                end
                send_tick();
                done++;
            end
            repeat ($urandom_range(3)) begin
                send_tick();
                done++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle ticks, full byte, dropped send, high nibble only
        send_tick();
        send_tick();
        offer_item(lcdbp_pkg::C_CMD_SEND, 8'hFF, 1'b1, 1'b0);
        offer_item(lcdbp_pkg::C_CMD_SEND, 8'h5A, 1'b0, 1'b1);
        while (ticks_left != 0)
            send_tick();
        send_tick();
        offer_item(lcdbp_pkg::C_CMD_SEND, 8'h00, 1'b0, 1'b1);
        while (ticks_left != 0)
            send_tick();
        send_tick();

        // Highest address, sender idling
        write_address(7'h7F);
        idle_pct = 54;
        run_sequences(PHASE_ITEMS);

        // Lowest address, receiver stalling, one long hold-off
        write_address(7'h00);
        idle_pct  = 0;
        stall_pct <= 54;
        hold_asks <= hold_asks + 1;
        run_sequences(PHASE_ITEMS);

        // Random address, both sides idling lightly
        write_address(7'($urandom_range(127)));
        idle_pct  = 17;
        stall_pct <= 17;
        run_sequences(PHASE_ITEMS);

        // Drain and report
        while (ticks_left != 0)
            send_tick();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
